// ===== rtl/core/indexed_shift_list_unit_defines.svh =====
// assertion macros shared by the indexed shift list modules
`ifndef INDEXED_SHIFT_LIST_UNIT_DEFINES_SVH
`define INDEXED_SHIFT_LIST_UNIT_DEFINES_SVH

// same-cycle implication, checked on aclk outside reset
`define ISL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define ISL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/isl_pkg.sv =====
// shared constants, codes and controller/datapath interface types
`default_nettype none

package isl_pkg;

    // default sizing
    localparam int DEPTH_DEF     = 64;
    localparam int WORD_BITS_DEF = 32;

    // fixed port widths
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // list operations
    typedef enum logic [CMD_W-1:0] {
        CMD_GET    = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_PUSH   = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_t;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // input transfer, latch item and update count
        logic capture;   // take ram read data as the result word
        logic rd_step;   // read the source entry of the current move
        logic wr_step;   // write the moved entry and step the pointer
        logic put_val;   // end of shift, place the insert word
        logic out_load;  // load the result register
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic acc_err;     // incoming item fails its range or full check
        logic acc_fetch;   // incoming get or remove needs a ram read
        logic acc_shift;   // incoming insert needs a shift pass
        logic reg_remove;  // held item is a remove
        logic more;        // shift pass has another entry to move
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/isl_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module isl_ram #(
    parameter  int WIDTH = isl_pkg::WORD_BITS_DEF,
    parameter  int DEPTH = isl_pkg::DEPTH_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/isl_ctrl.sv =====
// sequencing state machine for the indexed shift list
`default_nettype none
`include "indexed_shift_list_unit_defines.svh"

module isl_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire isl_pkg::dp_stat_t stat,
    output isl_pkg::dp_cmd_t       cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_RD    = 5'b00100,
        S_WR    = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.load   = accept;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (stat.acc_err) begin
                        state_next = S_RESP;
                    end else if (stat.acc_fetch) begin
                        state_next = S_FETCH;
                    end else if (stat.acc_shift) begin
                        state_next = S_RD;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_FETCH: begin
                cmd.capture = 1'b1;
                state_next  = stat.reg_remove ? S_RD : S_RESP;
            end
            S_RD: begin
                if (stat.more) begin
                    cmd.rd_step = 1'b1;
                    state_next  = S_WR;
                end else begin
                    cmd.put_val = 1'b1;
                    state_next  = S_RESP;
                end
            end
            S_WR: begin
                cmd.wr_step = 1'b1;
                state_next  = S_RD;
            end
            S_RESP: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // one item at a time, and a finished item always reaches the result register
    `ISL_ASSERT_NXT(a_one_item, accept, !s_ready, "new transfer taken while busy")
    `ISL_ASSERT_NXT(a_resp_done, (state_reg == S_RESP) && out_free, m_valid && s_ready,
        "result not delivered after response state")
    `ISL_ASSERT_NXT(a_wr_after_rd, cmd.rd_step, cmd.wr_step, "move read without write")

endmodule

`default_nettype wire

// ===== rtl/core/isl_dpath.sv =====
// list storage, count, shift pointer and result registers
`default_nettype none
`include "indexed_shift_list_unit_defines.svh"

module isl_dpath #(
    parameter int DEPTH     = isl_pkg::DEPTH_DEF,
    parameter int WORD_BITS = isl_pkg::WORD_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [isl_pkg::CMD_W-1:0]      s_cmd,
    input  wire logic [isl_pkg::INDEX_W-1:0]    s_index,
    input  wire logic [isl_pkg::VALUE_W-1:0]    s_value,
    input  wire isl_pkg::dp_cmd_t               cmd,
    output isl_pkg::dp_stat_t                   stat,
    output logic      [isl_pkg::VALUE_W-1:0]    m_read_value,
    output logic      [isl_pkg::STATUS_W-1:0]   m_status,
    output logic      [isl_pkg::COUNT_W-1:0]    m_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > isl_pkg::INDEX_W) ? CW : isl_pkg::INDEX_W;

    isl_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic [isl_pkg::VALUE_W-1:0]   val_reg, val_next;
    logic [AW-1:0]                 ptr_reg, ptr_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [isl_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [isl_pkg::VALUE_W-1:0]   rv_reg, rv_next;
    logic [isl_pkg::VALUE_W-1:0]   m_read_value_reg;
    logic [isl_pkg::STATUS_W-1:0]  m_status_reg;
    logic [isl_pkg::COUNT_W-1:0]   m_count_reg;

    logic [EW-1:0]                 idx_ext, cnt_ext;
    logic                          full;
    logic [isl_pkg::STATUS_W-1:0]  acc_status;
    logic [AW-1:0]                 ptr_step;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0]          ram_wdata, ram_rdata;

    // range and full checks on the incoming item
    assign idx_ext = EW'(s_index);
    assign cnt_ext = EW'(count_reg);
    assign full    = (count_reg == CW'(DEPTH));

    always_comb begin
        acc_status = isl_pkg::ST_OK;
        case (s_cmd)
            isl_pkg::CMD_GET, isl_pkg::CMD_REMOVE: begin
                if (idx_ext >= cnt_ext) begin
                    acc_status = isl_pkg::ST_RANGE;
                end
            end
            isl_pkg::CMD_INSERT: begin
                if (idx_ext > cnt_ext) begin
                    acc_status = isl_pkg::ST_RANGE;
                end else if (full) begin
                    acc_status = isl_pkg::ST_FULL;
                end
            end
            isl_pkg::CMD_PUSH: begin
                if (full) begin
                    acc_status = isl_pkg::ST_FULL;
                end
            end
            default: begin
                acc_status = isl_pkg::ST_OK;
            end
        endcase
    end

    // status toward the controller
    always_comb begin
        stat            = '0;
        stat.acc_err    = (acc_status != isl_pkg::ST_OK);
        stat.acc_fetch  = !stat.acc_err &&
                          (s_cmd == isl_pkg::CMD_GET || s_cmd == isl_pkg::CMD_REMOVE);
        stat.acc_shift  = !stat.acc_err && (s_cmd == isl_pkg::CMD_INSERT);
        stat.reg_remove = (cmd_reg == isl_pkg::CMD_REMOVE);
        if (cmd_reg == isl_pkg::CMD_INSERT) begin
            stat.more = (ptr_reg > idx_reg);
        end else if (cmd_reg == isl_pkg::CMD_REMOVE) begin
            stat.more = (CW'(ptr_reg) < count_reg);
        end
    end

    // shift pointer moves up through the list for remove, down for insert
    assign ptr_step = (cmd_reg == isl_pkg::CMD_REMOVE) ? ptr_reg + 1'b1 : ptr_reg - 1'b1;

    // ram port selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = WORD_BITS'(val_reg);
        if (cmd.load) begin
            ram_we    = !stat.acc_err && (s_cmd == isl_pkg::CMD_PUSH);
            ram_waddr = AW'(count_reg);
            ram_wdata = WORD_BITS'(s_value);
        end else if (cmd.wr_step) begin
            ram_we    = 1'b1;
            ram_waddr = ptr_reg;
            ram_wdata = ram_rdata;
        end else if (cmd.put_val) begin
            ram_we    = (cmd_reg == isl_pkg::CMD_INSERT);
        end
    end

    assign ram_raddr = cmd.rd_step ? ptr_step : AW'(s_index);

    isl_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // item, count and pointer updates
    always_comb begin
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        ptr_next    = ptr_reg;
        count_next  = count_reg;
        status_next = status_reg;
        rv_next     = rv_reg;
        if (cmd.load) begin
            cmd_next    = isl_pkg::cmd_t'(s_cmd);
            idx_next    = AW'(s_index);
            val_next    = s_value;
            status_next = acc_status;
            rv_next     = '0;
            if (!stat.acc_err) begin
                case (s_cmd)
                    isl_pkg::CMD_INSERT: begin
                        count_next = count_reg + 1'b1;
                        ptr_next   = AW'(count_reg);
                    end
                    isl_pkg::CMD_PUSH: begin
                        count_next = count_reg + 1'b1;
                    end
                    isl_pkg::CMD_REMOVE: begin
                        count_next = count_reg - 1'b1;
                        ptr_next   = AW'(s_index);
                    end
                    default: begin
                        count_next = count_reg;
                    end
                endcase
            end
        end
        if (cmd.capture) begin
            rv_next = isl_pkg::VALUE_W'(ram_rdata);
        end
        if (cmd.wr_step) begin
            ptr_next = ptr_step;
        end
    end

    // entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // held item and working registers
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        ptr_reg    <= ptr_next;
        status_reg <= status_next;
        rv_reg     <= rv_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_read_value_reg <= rv_reg;
            m_status_reg     <= status_reg;
            m_count_reg      <= isl_pkg::COUNT_W'(count_reg);
        end
    end

    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;
    assign m_count      = m_count_reg;

    // count stays within capacity and tracks successful pushes
    `ISL_ASSERT_IMP(a_count_cap, 1'b1, count_reg <= CW'(DEPTH), "entry count beyond capacity")
    `ISL_ASSERT_NXT(a_push_count, cmd.load && !stat.acc_err && s_cmd == isl_pkg::CMD_PUSH,
        count_reg == CW'($past(count_reg) + 1'b1), "push did not grow the count")
    `ISL_ASSERT_IMP(a_ins_ptr, cmd.wr_step && cmd_reg == isl_pkg::CMD_INSERT,
        ptr_reg > idx_reg, "insert move below the insert position")

endmodule

`default_nettype wire

// ===== rtl/core/indexed_shift_list_unit.sv =====
// indexed shift list: ordered word list with get, insert, push and remove
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   s_cmd, s_index, s_value
//   m_        out        m_valid / m_ready   m_read_value, m_status, m_count
//
// one item is in work at a time; entries live in a ram with one write and one
// registered read port, so every moved entry takes a read step and a write step.
// reset clears the count, the state and the result valid flag; a waiting result
// stalls the block in its response step.
`default_nettype none

module indexed_shift_list_unit #(
    parameter int DEPTH     = isl_pkg::DEPTH_DEF,
    parameter int WORD_BITS = isl_pkg::WORD_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [isl_pkg::CMD_W-1:0]      s_cmd,
    input  wire logic [isl_pkg::INDEX_W-1:0]    s_index,
    input  wire logic [isl_pkg::VALUE_W-1:0]    s_value,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [isl_pkg::VALUE_W-1:0]    m_read_value,
    output logic      [isl_pkg::STATUS_W-1:0]   m_status,
    output logic      [isl_pkg::COUNT_W-1:0]    m_count
);

    isl_pkg::dp_cmd_t  dp_cmd;
    isl_pkg::dp_stat_t dp_stat;

    // sequencer
    isl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    // storage and result path
    isl_dpath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_cmd        (s_cmd),
        .s_index      (s_index),
        .s_value      (s_value),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_count      (m_count)
    );

endmodule

`default_nettype wire
